>>> hw/rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// Decimal digit formatter package
// Shared types and constants for the formatter's front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ddf_pkg;

    // Largest field width in decimal places.
    localparam int unsigned MAX_DIGITS = 10;
    // Decimal places needed to hold any 32-bit value.
    localparam int unsigned DEC_DIGITS = 10;
    // Depth of the job queue between the front and the back end.
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned CFG_IDX_W = 8;

    // Padding modes.
    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_ZEROS = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CHAR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUESTION_CHAR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_CHAR    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR      = 8'd3;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  pad_mode;
        logic [3:0]  digit_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last;
    } t_out_item;

    typedef logic [DEC_DIGITS-1:0][3:0] t_bcd;

    // One converted item as it travels from the front to the back end.
    typedef struct packed {
        t_bcd       digits;
        logic [1:0] pad_mode;
        logic [3:0] places;
    } t_job;

    typedef struct packed {
        logic [15:0] zero_char;
        logic [15:0] question_char;
        logic [15:0] space_char;
        logic [15:0] end_char;
    } t_cfg;

endpackage

`default_nettype wire

>>> hw/rtl/ddf_conv.sv
// ----------------------------------------------------------------------------
// Decimal digit formatter front end
// Accepts an item, clamps the field width and converts the value to BCD.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_conv
    import ddf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    output logic          o_busy,
    output logic          o_push,
    output t_job          o_job,
    input  wire logic     i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    t_bcd        r_digits, n_digits;
    logic [1:0]  r_mode, n_mode;
    logic [3:0]  r_places, n_places;

    // One shift-and-add-three step of the binary to BCD conversion.
    function automatic t_bcd dabble(input t_bcd d, input logic b);
        t_bcd        a;
        logic [40:0] w;
        a = d;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (a[k] >= 4'd5) begin
                a[k] = a[k] + 4'd3;
            end
        end
        w = {a, b};
        return w[39:0];
    endfunction

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_digits = r_digits;
        n_mode   = r_mode;
        n_places = r_places;
        o_push   = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_shift  = i_item.value;
                    n_digits = '0;
                    n_cnt    = 4'd0;
                    n_mode   = i_item.pad_mode;
                    if (i_item.digit_count == 4'd0) begin
                        n_places = 4'd1;
                    end else if (i_item.digit_count > 4'(MAX_DIGITS)) begin
                        n_places = 4'(MAX_DIGITS);
                    end else begin
                        n_places = i_item.digit_count;
                    end
                    n_state = F_CONV;
                end
            end
            F_CONV: begin
                // Two value bits enter the BCD register per cycle.
                n_digits = dabble(dabble(r_digits, r_shift[31]), r_shift[30]);
                n_shift  = {r_shift[29:0], 2'b00};
                n_cnt    = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_shift  <= n_shift;
        r_digits <= n_digits;
        r_mode   <= n_mode;
        r_places <= n_places;
    end

    assign o_busy         = (r_state != F_IDLE);
    assign o_job.digits   = r_digits;
    assign o_job.pad_mode = r_mode;
    assign o_job.places   = r_places;

endmodule

`default_nettype wire

>>> hw/rtl/ddf_queue.sv
// ----------------------------------------------------------------------------
// Decimal digit formatter job queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_queue
    import ddf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

`default_nettype wire

>>> hw/rtl/ddf_emit.sv
// ----------------------------------------------------------------------------
// Decimal digit formatter back end
// Walks the places of a converted item and emits at most one character per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_emit
    import ddf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_res
);

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_DIGIT = 3'b010,
        E_TERM  = 3'b100
    } t_estate;

    t_estate    r_state, n_state;
    t_job       r_job, n_job;
    logic [3:0] r_pos, n_pos;
    logic       r_print, n_print;
    logic       r_strobe, n_strobe;
    t_out_item  r_res, n_res;

    logic [3:0] w_idx;
    logic [3:0] w_digit;
    logic       w_above;
    logic       w_ovf;
    logic       w_nz;

    assign w_idx   = r_pos - 4'd1;
    assign w_digit = r_job.digits[w_idx];

    // Any nonzero digit above the current place makes the top quotient ten or more.
    always_comb begin
        w_above = 1'b0;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if ((4'(k) > w_idx) && (r_job.digits[k] != 4'd0)) begin
                w_above = 1'b1;
            end
        end
    end

    assign w_ovf = (r_pos == r_job.places) && w_above;
    assign w_nz  = (w_digit != 4'd0) || w_ovf;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_pos    = r_pos;
        n_print  = r_print;
        n_strobe = 1'b0;
        n_res    = r_res;
        o_pop    = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_pos   = i_job.places;
                    n_print = (i_job.pad_mode == MODE_ZEROS);
                    n_state = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (r_print || w_nz || (r_pos == 4'd1)) begin
                    n_strobe   = 1'b1;
                    n_print    = 1'b1;
                    n_res.last = 1'b0;
                    if (w_ovf) begin
                        n_res.char_code = i_cfg.question_char;
                    end else begin
                        n_res.char_code = i_cfg.zero_char + {12'd0, w_digit};
                    end
                end else if (r_job.pad_mode == MODE_RIGHT) begin
                    n_strobe        = 1'b1;
                    n_res.last      = 1'b0;
                    n_res.char_code = i_cfg.space_char;
                end
                if (r_pos == 4'd1) begin
                    n_state = E_TERM;
                end else begin
                    n_pos = r_pos - 4'd1;
                end
            end
            E_TERM: begin
                n_strobe        = 1'b1;
                n_res.last      = 1'b1;
                n_res.char_code = i_cfg.end_char;
                n_state         = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_pos    <= 4'd1;
            r_print  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_print  <= n_print;
            r_strobe <= n_strobe;
        end
        r_job <= n_job;
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

>>> hw/rtl/decimal_digit_formatter_top.sv
// ----------------------------------------------------------------------------
// Decimal digit formatter
// Turns an unsigned 32-bit value into a run of decimal character codes.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. The front end
// then turns the value into BCD, two bits per cycle, and hands the job to a
// two-entry queue, waiting while the queue is full, so busy stays high from
// the accepting edge until the job is queued and no new item is taken
// before that; that converter loop sets the rate. The back end drains the
// queue on its own, one place per cycle, and its results are registered.
// Each item yields between two and eleven results, the terminator last
// with last set; a skipped leading place in left-align mode gives no
// strobe. Each result on o_res is flagged by o_res_strobe for exactly one
// cycle and the receiver cannot stall the results. Character codes are set
// through the configuration channel, which is always ready; write it only
// while no item is in flight.
`default_nettype none

module decimal_digit_formatter_top
    import ddf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Item input.
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in_item             i_item,
    // Result output.
    output logic                      o_res_strobe,
    output t_out_item                 o_res,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // The register file takes a write in every cycle, so the channel is
    // always ready. Indexes beyond the register list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_char     <= 16'd162;
            r_cfg.question_char <= 16'd240;
            r_cfg.space_char    <= 16'd1;
            r_cfg.end_char      <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ZERO_CHAR:     r_cfg.zero_char     <= i_cfg_data;
                CFG_QUESTION_CHAR: r_cfg.question_char <= i_cfg_data;
                CFG_SPACE_CHAR:    r_cfg.space_char    <= i_cfg_data;
                CFG_END_CHAR:      r_cfg.end_char      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end clamps the width and converts the value to BCD.
    ddf_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    // The queue lets the next conversion run while earlier runs are printed.
    ddf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    // The back end walks one place per cycle and ends with the terminator.
    ddf_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_job    (w_pop_job),
        .o_pop    (w_pop),
        .o_strobe (o_res_strobe),
        .o_res    (o_res)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    // An accepted item keeps the front end busy in the following cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("front end not busy after accepting an item");

    // A job always has at least one place to walk, so the terminator never
    // follows a pop directly.
    a_no_early_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !(o_res_strobe && o_res.last))
        else $error("terminator emitted right after a job was taken");

endmodule

`default_nettype wire
